// ----- hdl/pcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants for the serial command decoder: timing pairs,
// command characters and the state and result records.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int MAX_DIGITS_DEF = 3;

	// widest decimal value that three digits can form (999)
	localparam int VAL_W  = 10;
	localparam int BYTE_W = 8;
	localparam int UP_W   = 9;
	localparam int LO_W   = 11;
	localparam int OBS_W  = 8;
	localparam int DIG_W  = 4;

	localparam logic [UP_W-1:0]  UP_NORMAL   = UP_W'(400);
	localparam logic [LO_W-1:0]  LO_NORMAL   = LO_W'(1000);
	localparam logic [UP_W-1:0]  UP_SLEEP    = UP_W'(500);
	localparam logic [LO_W-1:0]  LO_SLEEP    = LO_W'(1200);
	localparam logic [UP_W-1:0]  UP_EXERCISE = UP_W'(300);
	localparam logic [LO_W-1:0]  LO_EXERCISE = LO_W'(800);
	localparam logic [UP_W-1:0]  UP_MANUAL   = UP_W'(300);
	localparam logic [LO_W-1:0]  LO_MANUAL   = LO_W'(1200);
	localparam logic [OBS_W-1:0] OBS_RESET   = OBS_W'(1);
	localparam logic [VAL_W-1:0] OBS_LIMIT   = VAL_W'(256);
	localparam logic [VAL_W-1:0] DEC_BASE    = VAL_W'(10);

	localparam logic [BYTE_W-1:0] CHR_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [BYTE_W-1:0] CHR_DIGIT_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CHR_DIGIT_9 = 8'h39;
	localparam logic [BYTE_W-1:0] CHR_LF      = 8'h0A;
	localparam logic [BYTE_W-1:0] CHR_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] CMD_NORMAL  = 8'h6E; // n
	localparam logic [BYTE_W-1:0] CMD_SLEEP   = 8'h73; // s
	localparam logic [BYTE_W-1:0] CMD_EXER    = 8'h65; // e
	localparam logic [BYTE_W-1:0] CMD_MANUAL  = 8'h6D; // m
	localparam logic [BYTE_W-1:0] CMD_ATRIAL  = 8'h61; // a
	localparam logic [BYTE_W-1:0] CMD_VENT    = 8'h76; // v
	localparam logic [BYTE_W-1:0] CMD_OBS     = 8'h6F; // o

	typedef struct packed {
		logic             entry;
		logic             manual;
		logic [UP_W-1:0]  upper;
		logic [LO_W-1:0]  lower;
		logic [OBS_W-1:0] obs;
	} pcd_state_t;

	typedef struct packed {
		logic [UP_W-1:0]  upper;
		logic [LO_W-1:0]  lower;
		logic [OBS_W-1:0] obs;
		logic             manual;
		logic             force_a;
		logic             force_v;
	} pcd_result_t;

endpackage
`default_nettype wire

// ----- hdl/pcd_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_decoder
// Next-state and result logic for one received byte: command decode,
// decimal entry window and observation interval load.
// ----------------------------------------------------------------------------
module pcd_decoder #(
	parameter int MAX_DIGITS = pcd_pkg::MAX_DIGITS_DEF,
	localparam int WIN   = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 3) ? 3 : MAX_DIGITS),
	localparam int CNT_W = $clog2(WIN + 1),
	localparam int IDX_W = (WIN > 1) ? $clog2(WIN) : 1
) (
	input  wire logic [pcd_pkg::BYTE_W-1:0] key_byte,
	input  wire pcd_pkg::pcd_state_t        cur_state,
	input  wire logic [CNT_W-1:0]           cur_count,
	input  wire logic [pcd_pkg::DIG_W-1:0]  cur_win [WIN],
	output pcd_pkg::pcd_state_t             nxt_state,
	output logic [CNT_W-1:0]                nxt_count,
	output logic [pcd_pkg::DIG_W-1:0]       nxt_win [WIN],
	output pcd_pkg::pcd_result_t            result
);

	logic [pcd_pkg::BYTE_W-1:0] lc;
	logic [pcd_pkg::VAL_W-1:0]  value;
	logic                       is_digit;
	logic                       is_eol;
	logic                       fa;
	logic                       fv;

	assign is_digit = (key_byte >= pcd_pkg::CHR_DIGIT_0) && (key_byte <= pcd_pkg::CHR_DIGIT_9);
	assign is_eol   = (key_byte == pcd_pkg::CHR_LF) || (key_byte == pcd_pkg::CHR_CR);

	// fold upper-case letters down
	always_comb begin
		if ((key_byte >= pcd_pkg::CHR_UPPER_A) && (key_byte <= pcd_pkg::CHR_UPPER_Z)) begin
			lc = key_byte + pcd_pkg::CASE_OFFSET;
		end else begin
			lc = key_byte;
		end
	end

	// accumulate the held digits, oldest first
	always_comb begin
		value = '0;
		for (int i = 0; i < WIN; i++) begin
			if (CNT_W'(i) < cur_count) begin
				value = pcd_pkg::VAL_W'(value * pcd_pkg::DEC_BASE
					+ pcd_pkg::VAL_W'(cur_win[i]));
			end
		end
	end

	always_comb begin
		nxt_state = cur_state;
		nxt_count = cur_count;
		nxt_win   = cur_win;
		fa        = 1'b0;
		fv        = 1'b0;
		if (cur_state.entry) begin
			if (is_digit) begin
				if (cur_count < CNT_W'(WIN)) begin
					nxt_win[cur_count[IDX_W-1:0]] = key_byte[pcd_pkg::DIG_W-1:0];
					nxt_count = cur_count + CNT_W'(1);
				end else begin
					// drop the oldest digit
					for (int i = 0; i + 1 < WIN; i++) begin
						nxt_win[i] = cur_win[i + 1];
					end
					nxt_win[WIN-1] = key_byte[pcd_pkg::DIG_W-1:0];
				end
			end else if (is_eol) begin
				if ((value != '0) && (value < pcd_pkg::OBS_LIMIT)) begin
					nxt_state.obs = value[pcd_pkg::OBS_W-1:0];
				end
				nxt_state.entry = 1'b0;
			end
		end else begin
			case (lc)
				pcd_pkg::CMD_NORMAL: begin
					nxt_state.upper  = pcd_pkg::UP_NORMAL;
					nxt_state.lower  = pcd_pkg::LO_NORMAL;
					nxt_state.manual = 1'b0;
				end
				pcd_pkg::CMD_SLEEP: begin
					nxt_state.upper  = pcd_pkg::UP_SLEEP;
					nxt_state.lower  = pcd_pkg::LO_SLEEP;
					nxt_state.manual = 1'b0;
				end
				pcd_pkg::CMD_EXER: begin
					nxt_state.upper  = pcd_pkg::UP_EXERCISE;
					nxt_state.lower  = pcd_pkg::LO_EXERCISE;
					nxt_state.manual = 1'b0;
				end
				pcd_pkg::CMD_MANUAL: begin
					if (!cur_state.manual) begin
						nxt_state.upper  = pcd_pkg::UP_MANUAL;
						nxt_state.lower  = pcd_pkg::LO_MANUAL;
						nxt_state.manual = 1'b1;
					end else begin
						nxt_state.upper  = pcd_pkg::UP_NORMAL;
						nxt_state.lower  = pcd_pkg::LO_NORMAL;
						nxt_state.manual = 1'b0;
					end
				end
				pcd_pkg::CMD_ATRIAL: begin
					fa = cur_state.manual;
				end
				pcd_pkg::CMD_VENT: begin
					fv = cur_state.manual;
				end
				pcd_pkg::CMD_OBS: begin
					nxt_state.entry = 1'b1;
					nxt_count       = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.upper   = nxt_state.upper;
	assign result.lower   = nxt_state.lower;
	assign result.obs     = nxt_state.obs;
	assign result.manual  = nxt_state.manual;
	assign result.force_a = fa;
	assign result.force_v = fv;

endmodule
`default_nettype wire

// ----- hdl/pacing_command_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pacing_command_decoder_top
// Serial command decoder: one received byte in, one timing/status beat out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with key_byte. A beat is taken at a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the six result fields. Every
// input beat produces exactly one output beat, in order.
// Path: a taken byte lands in the input register, and its result is loaded
// into the result register when the byte advances (two register stages).
// Throughput: one byte per cycle while out_stall stays low; decode is a single short pass
// of logic between the input register and the result register.
// Stall: while out_stall holds a waiting result, the input register keeps
// advancing only if the result register frees up; once both stages are
// full, in_stall rises until the receiver takes the waiting beat.
// Reset (arst_n low): normal timing pair 400/1000, observation interval 1,
// manual mode off, no entry in progress, both stages empty.
// ----------------------------------------------------------------------------
module pacing_command_decoder_top #(
	parameter int MAX_DIGITS = pcd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [pcd_pkg::BYTE_W-1:0]  key_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [pcd_pkg::UP_W-1:0]         upper_rate_interval_ms,
	output logic [pcd_pkg::LO_W-1:0]         lower_rate_interval_ms,
	output logic [pcd_pkg::OBS_W-1:0]        observation_interval,
	output logic                             manual_active,
	output logic                             force_atrial_pace,
	output logic                             force_ventricular_pace
);

	localparam int WIN   = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 3) ? 3 : MAX_DIGITS);
	localparam int CNT_W = $clog2(WIN + 1);

	// input stage
	logic                       valid_s1;
	logic [pcd_pkg::BYTE_W-1:0] key_s1;

	// decoder state
	pcd_pkg::pcd_state_t        state_q;
	logic [CNT_W-1:0]           count_q;
	logic [pcd_pkg::DIG_W-1:0]  win_q [WIN];

	// result stage
	logic                       valid_s2;
	pcd_pkg::pcd_result_t       res_s2;

	pcd_pkg::pcd_state_t        nxt_state;
	logic [CNT_W-1:0]           nxt_count;
	logic [pcd_pkg::DIG_W-1:0]  nxt_win [WIN];
	pcd_pkg::pcd_result_t       result;

	logic                       adv_s2;
	logic                       adv_s1;
	logic                       take_in;

	// the result register can load when empty or when its beat leaves now
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign take_in  = in_valid && !in_stall;

	pcd_decoder #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dec (
		.key_byte  (key_s1),
		.cur_state (state_q),
		.cur_count (count_q),
		.cur_win   (win_q),
		.nxt_state (nxt_state),
		.nxt_count (nxt_count),
		.nxt_win   (nxt_win),
		.result    (result)
	);

	// input register: hold while the byte cannot move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			key_s1 <= key_byte;
		end
	end

	// commit the decoder state only when the byte advances into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.entry  <= 1'b0;
			state_q.manual <= 1'b0;
			state_q.upper  <= pcd_pkg::UP_NORMAL;
			state_q.lower  <= pcd_pkg::LO_NORMAL;
			state_q.obs    <= pcd_pkg::OBS_RESET;
			count_q        <= '0;
			for (int i = 0; i < WIN; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			state_q <= nxt_state;
			count_q <= nxt_count;
			win_q   <= nxt_win;
		end
	end

	// result register: load on advance, drop the valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= result;
		end
	end

	assign out_valid              = valid_s2;
	assign upper_rate_interval_ms = res_s2.upper;
	assign lower_rate_interval_ms = res_s2.lower;
	assign observation_interval   = res_s2.obs;
	assign manual_active          = res_s2.manual;
	assign force_atrial_pace      = res_s2.force_a;
	assign force_ventricular_pace = res_s2.force_v;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial command decoder. A short table of
// directed key bytes covers the reset state, every command in one case or both,
// forced paces in and out of manual mode, and the edge cases of decimal entry.
// A random mix of well-formed commands, entry sequences and line noise follows.
// Every result beat is checked against its pinned row or an in-bench decoder,
// with random idling on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int MAX_REPORTS     = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam int N_DIRECTED      = 27;
	// the decimal window length, clamped into 1..3 as the block does
	localparam int WIN_LEN = (pcd_pkg::MAX_DIGITS_DEF < 1) ? 1 :
		((pcd_pkg::MAX_DIGITS_DEF > 3) ? 3 : pcd_pkg::MAX_DIGITS_DEF);

	localparam logic [pcd_pkg::BYTE_W-1:0] KEY_NUL = 8'h00;
	localparam logic [pcd_pkg::BYTE_W-1:0] KEY_MAX = 8'hFF;
	localparam logic [pcd_pkg::BYTE_W-1:0] KEY_2   = pcd_pkg::CHR_DIGIT_0 + 8'd2;
	localparam logic [pcd_pkg::BYTE_W-1:0] KEY_5   = pcd_pkg::CHR_DIGIT_0 + 8'd5;
	localparam logic [pcd_pkg::BYTE_W-1:0] KEY_9   = pcd_pkg::CHR_DIGIT_9;

	localparam logic PIN  = 1'b1;
	localparam logic FREE = 1'b0;

	// expected status beats that can be read straight off the command set
	localparam pcd_pkg::pcd_result_t NO_STATUS   = '0;
	localparam pcd_pkg::pcd_result_t ST_NORMAL   = '{pcd_pkg::UP_NORMAL, pcd_pkg::LO_NORMAL,
		pcd_pkg::OBS_RESET, 1'b0, 1'b0, 1'b0};
	localparam pcd_pkg::pcd_result_t ST_MANUAL   = '{pcd_pkg::UP_MANUAL, pcd_pkg::LO_MANUAL,
		pcd_pkg::OBS_RESET, 1'b1, 1'b0, 1'b0};
	localparam pcd_pkg::pcd_result_t ST_ATRIAL   = '{pcd_pkg::UP_MANUAL, pcd_pkg::LO_MANUAL,
		pcd_pkg::OBS_RESET, 1'b1, 1'b1, 1'b0};
	localparam pcd_pkg::pcd_result_t ST_VENT     = '{pcd_pkg::UP_MANUAL, pcd_pkg::LO_MANUAL,
		pcd_pkg::OBS_RESET, 1'b1, 1'b0, 1'b1};
	localparam pcd_pkg::pcd_result_t ST_SLEEP    = '{pcd_pkg::UP_SLEEP, pcd_pkg::LO_SLEEP,
		pcd_pkg::OBS_RESET, 1'b0, 1'b0, 1'b0};
	localparam pcd_pkg::pcd_result_t ST_EXERCISE = '{pcd_pkg::UP_EXERCISE, pcd_pkg::LO_EXERCISE,
		pcd_pkg::OBS_RESET, 1'b0, 1'b0, 1'b0};
	localparam pcd_pkg::pcd_result_t ST_OBS_TOP  = '{pcd_pkg::UP_NORMAL, pcd_pkg::LO_NORMAL,
		pcd_pkg::OBS_W'(255), 1'b0, 1'b0, 1'b0};

	typedef struct packed {
		logic [pcd_pkg::BYTE_W-1:0] key;
		logic                       pinned;
		pcd_pkg::pcd_result_t       want;
	} key_step_t;

	// directed key sequence; rows marked FREE are checked against the decoder model
	localparam key_step_t DIRECTED [N_DIRECTED] = '{
		'{KEY_NUL, PIN, ST_NORMAL},                   // state right after reset
		'{KEY_MAX, PIN, ST_NORMAL},                   // high byte, not a command
		'{pcd_pkg::CMD_ATRIAL, PIN, ST_NORMAL},       // atrial force outside manual: no pulse
		'{pcd_pkg::CMD_MANUAL - pcd_pkg::CASE_OFFSET, PIN, ST_MANUAL}, // enter manual, upper case
		'{pcd_pkg::CMD_ATRIAL, PIN, ST_ATRIAL},
		'{pcd_pkg::CMD_VENT - pcd_pkg::CASE_OFFSET, PIN, ST_VENT},
		'{pcd_pkg::CMD_MANUAL, PIN, ST_NORMAL},       // leave manual
		'{pcd_pkg::CMD_SLEEP - pcd_pkg::CASE_OFFSET, PIN, ST_SLEEP},
		'{pcd_pkg::CMD_EXER, PIN, ST_EXERCISE},
		'{pcd_pkg::CMD_NORMAL - pcd_pkg::CASE_OFFSET, PIN, ST_NORMAL},
		'{pcd_pkg::CMD_OBS, FREE, NO_STATUS},         // largest interval that loads
		'{KEY_2, FREE, NO_STATUS},
		'{KEY_5, FREE, NO_STATUS},
		'{KEY_5, FREE, NO_STATUS},
		'{pcd_pkg::CHR_CR, PIN, ST_OBS_TOP},
		'{pcd_pkg::CMD_OBS, FREE, NO_STATUS},         // four digits, letter inside, 999 kept out
		'{KEY_2, FREE, NO_STATUS},
		'{pcd_pkg::CMD_ATRIAL - pcd_pkg::CASE_OFFSET, FREE, NO_STATUS},
		'{KEY_9, FREE, NO_STATUS},
		'{KEY_9, FREE, NO_STATUS},
		'{KEY_9, FREE, NO_STATUS},
		'{pcd_pkg::CHR_LF, FREE, NO_STATUS},
		'{pcd_pkg::CMD_OBS, FREE, NO_STATUS},         // empty entry
		'{pcd_pkg::CHR_LF, FREE, NO_STATUS},
		'{pcd_pkg::CMD_OBS, FREE, NO_STATUS},         // entry of zero
		'{pcd_pkg::CHR_DIGIT_0, FREE, NO_STATUS},
		'{pcd_pkg::CHR_CR, FREE, NO_STATUS}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [pcd_pkg::BYTE_W-1:0] key_byte;
	logic                       out_valid;
	logic                       out_stall;
	logic [pcd_pkg::UP_W-1:0]   upper_rate_interval_ms;
	logic [pcd_pkg::LO_W-1:0]   lower_rate_interval_ms;
	logic [pcd_pkg::OBS_W-1:0]  observation_interval;
	logic                       manual_active;
	logic                       force_atrial_pace;
	logic                       force_ventricular_pace;

	// decoder model state
	logic                       entry_on;
	int                         digit_cnt;
	logic [pcd_pkg::DIG_W-1:0]  digit_win [3];
	logic                       manual_on;
	logic [pcd_pkg::UP_W-1:0]   upper_ms;
	logic [pcd_pkg::LO_W-1:0]   lower_ms;
	logic [pcd_pkg::OBS_W-1:0]  obs_val;

	pcd_pkg::pcd_result_t       awaited_status [$];
	int                         src_idle_pct;
	int                         sink_stall_pct;
	int                         items_sent;
	int                         bytes_sent;
	int                         beats_checked;
	int                         obs_loads;
	int                         forced_paces;
	int                         mismatches;
	int                         cycle_count;

	pacing_command_decoder_top u_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.key_byte               (key_byte),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.upper_rate_interval_ms (upper_rate_interval_ms),
		.lower_rate_interval_ms (lower_rate_interval_ms),
		.observation_interval   (observation_interval),
		.manual_active          (manual_active),
		.force_atrial_pace      (force_atrial_pace),
		.force_ventricular_pace (force_ventricular_pace)
	);

	always #(CLK_HALF) clk = ~clk;

	// Decode one key byte against the model state and return the status beat
	// it should produce. Advances the model state as a side effect.
	function automatic pcd_pkg::pcd_result_t next_status(
			input logic [pcd_pkg::BYTE_W-1:0] b);
		pcd_pkg::pcd_result_t       st;
		logic [pcd_pkg::BYTE_W-1:0] lc;
		logic [pcd_pkg::DIG_W-1:0]  d;
		int                         val;
		st = '0;
		if (entry_on) begin
			if (b >= pcd_pkg::CHR_DIGIT_0 && b <= pcd_pkg::CHR_DIGIT_9) begin
				d = pcd_pkg::DIG_W'(b - pcd_pkg::CHR_DIGIT_0);
				if (digit_cnt < WIN_LEN) begin
					digit_win[digit_cnt] = d;
					digit_cnt++;
				end else begin
					// window full: drop the oldest digit, shift, append
					for (int i = 0; i < WIN_LEN - 1; i++)
						digit_win[i] = digit_win[i + 1];
					digit_win[WIN_LEN - 1] = d;
				end
			end else if (b == pcd_pkg::CHR_CR || b == pcd_pkg::CHR_LF) begin
				val = 0;
				for (int i = 0; i < digit_cnt; i++)
					val = val * 10 + int'(digit_win[i]);
				// zero and anything past the byte range leave the interval alone
				if (val != 0 && val < int'(pcd_pkg::OBS_LIMIT)) begin
					obs_val = pcd_pkg::OBS_W'(val);
					obs_loads++;
				end
				entry_on = 1'b0;
			end
			// any other byte is swallowed while entry is open
		end else begin
			lc = (b >= pcd_pkg::CHR_UPPER_A && b <= pcd_pkg::CHR_UPPER_Z) ?
				b + pcd_pkg::CASE_OFFSET : b;
			case (lc)
				pcd_pkg::CMD_NORMAL: begin
					upper_ms = pcd_pkg::UP_NORMAL; lower_ms = pcd_pkg::LO_NORMAL;
					manual_on = 1'b0;
				end
				pcd_pkg::CMD_SLEEP: begin
					upper_ms = pcd_pkg::UP_SLEEP; lower_ms = pcd_pkg::LO_SLEEP;
					manual_on = 1'b0;
				end
				pcd_pkg::CMD_EXER: begin
					upper_ms = pcd_pkg::UP_EXERCISE; lower_ms = pcd_pkg::LO_EXERCISE;
					manual_on = 1'b0;
				end
				pcd_pkg::CMD_MANUAL: begin
					if (manual_on) begin
						upper_ms = pcd_pkg::UP_NORMAL; lower_ms = pcd_pkg::LO_NORMAL;
					end else begin
						upper_ms = pcd_pkg::UP_MANUAL; lower_ms = pcd_pkg::LO_MANUAL;
					end
					manual_on = ~manual_on;
				end
				pcd_pkg::CMD_ATRIAL: st.force_a = manual_on;
				pcd_pkg::CMD_VENT:   st.force_v = manual_on;
				pcd_pkg::CMD_OBS: begin
					entry_on = 1'b1; digit_cnt = 0;
				end
				default: ;
			endcase
		end
		st.upper  = upper_ms;
		st.lower  = lower_ms;
		st.obs    = obs_val;
		st.manual = manual_on;
		forced_paces += int'(st.force_a) + int'(st.force_v);
		return st;
	endfunction

	// Offer one key beat: idle for a random stretch, present the byte, hold it
	// until taken, then queue the status it should produce.
	task automatic send_byte(input logic [pcd_pkg::BYTE_W-1:0] b, input logic pinned,
			input pcd_pkg::pcd_result_t want);
		pcd_pkg::pcd_result_t pred;
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		key_byte <= b;
		do @(posedge clk); while (in_stall);
		pred = next_status(b);
		awaited_status.push_back(pinned ? want : pred);
		bytes_sent++;
	endtask

	// Hold the input idle until every queued status beat has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_command();
		logic [pcd_pkg::BYTE_W-1:0] k;
		case ($urandom_range(8))
			0:       k = pcd_pkg::CMD_NORMAL;
			1:       k = pcd_pkg::CMD_SLEEP;
			2:       k = pcd_pkg::CMD_EXER;
			3, 4:    k = pcd_pkg::CMD_MANUAL;
			5, 6:    k = pcd_pkg::CMD_ATRIAL;
			default: k = pcd_pkg::CMD_VENT;
		endcase
		if ($urandom_range(1) == 1)
			k = k - pcd_pkg::CASE_OFFSET;
		send_byte(k, FREE, NO_STATUS);
		items_sent++;
	endtask

	// Open an entry, key in a few digits with the odd stray byte between them,
	// and usually close it with CR or LF.
	task automatic send_entry();
		int n_dig;
		n_dig = ($urandom_range(3) == 0) ? $urandom_range(5) : $urandom_range(3, 1);
		send_byte(($urandom_range(1) == 1) ? pcd_pkg::CMD_OBS :
			pcd_pkg::CMD_OBS - pcd_pkg::CASE_OFFSET, FREE, NO_STATUS);
		items_sent++;
		for (int i = 0; i < n_dig; i++) begin
			if ($urandom_range(9) == 0)
				send_byte(pcd_pkg::BYTE_W'($urandom), FREE, NO_STATUS);
			send_byte(pcd_pkg::BYTE_W'(pcd_pkg::CHR_DIGIT_0 + $urandom_range(9)),
				FREE, NO_STATUS);
			items_sent++;
		end
		if ($urandom_range(9) != 0) begin
			send_byte(($urandom_range(1) == 1) ? pcd_pkg::CHR_CR : pcd_pkg::CHR_LF,
				FREE, NO_STATUS);
			items_sent++;
		end
	endtask

	// One random phase at a given idle/stall mix, drained at the end.
	task automatic run_phase(input int src_pct, input int sink_pct);
		int target;
		int pick;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		target = bytes_sent + ITEMS_PER_PHASE;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_command();
			else if (pick < 78)
				send_entry();
			else
				send_byte(pcd_pkg::BYTE_W'($urandom), FREE, NO_STATUS);  // line noise
		end
		drain();
	endtask

	// Compare one taken status beat, field by field, with the oldest one queued.
	task automatic check_beat();
		pcd_pkg::pcd_result_t got;
		pcd_pkg::pcd_result_t want;
		got = '{upper_rate_interval_ms, lower_rate_interval_ms, observation_interval,
			manual_active, force_atrial_pace, force_ventricular_pace};
		if (awaited_status.size() == 0) begin
			if (mismatches < MAX_REPORTS)
				$display("[%0t] status beat with nothing queued: up=%0d lo=%0d obs=%0d",
					$realtime, got.upper, got.lower, got.obs);
			mismatches++;
		end else begin
			want = awaited_status.pop_front();
			beats_checked++;
			if (got.upper !== want.upper || got.lower !== want.lower ||
					got.obs !== want.obs || got.manual !== want.manual ||
					got.force_a !== want.force_a || got.force_v !== want.force_v) begin
				if (mismatches < MAX_REPORTS) begin
					$display("[%0t] beat %0d exp up=%0d lo=%0d obs=%0d man=%b fa=%b fv=%b",
						$realtime, beats_checked, want.upper, want.lower, want.obs,
						want.manual, want.force_a, want.force_v);
					$display("[%0t] beat %0d got up=%0d lo=%0d obs=%0d man=%b fa=%b fv=%b",
						$realtime, beats_checked, got.upper, got.lower, got.obs,
						got.manual, got.force_a, got.force_v);
				end
				mismatches++;
			end
		end
	endtask

	// Receiver: stall at random, driven on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// Take a status beat whenever valid is up and we are not stalling.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_beat();
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still queued",
				cycle_count, awaited_status.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		key_byte  = '0;
		out_stall = 1'b0;
		// model state after reset: normal pair, interval 1, no manual, no entry
		entry_on  = 1'b0;
		digit_cnt = 0;
		digit_win = '{default: '0};
		manual_on = 1'b0;
		upper_ms  = pcd_pkg::UP_NORMAL;
		lower_ms  = pcd_pkg::LO_NORMAL;
		obs_val   = pcd_pkg::OBS_RESET;
		items_sent = 0; bytes_sent = 0; beats_checked = 0;
		obs_loads = 0; forced_paces = 0; mismatches = 0; cycle_count = 0;
		// directed rows run under a lightly idling sender and a heavily stalling receiver
		src_idle_pct   = 15;
		sink_stall_pct = 83;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(DIRECTED[i].key, DIRECTED[i].pinned, DIRECTED[i].want);
		// hold off until the directed beats are all back
		drain();

		// random traffic: sparse sender idling, then heavy, then none at all
		run_phase(15, 83);
		run_phase(83, 15);
		run_phase(0, 0);

		// let any stray late beat show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d key bytes sent (%0d commands and digits), %0d status beats checked",
			bytes_sent, items_sent, beats_checked);
		$display("%0d observation interval loads, %0d forced paces, %0d mismatches",
			obs_loads, forced_paces, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- pacing_command_decoder_top.f -----
hdl/pcd_pkg.sv
hdl/pcd_decoder.sv
hdl/pacing_command_decoder_top.sv
tb/tb.sv
